FILE: hw/rtl/ffpra_pkg.sv
package ffpra_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGES_W     = 52;
    localparam int ADDR_W      = 64;
    localparam int TYPE_W      = 16;
    localparam int ENTRY_W     = ADDR_W + PAGES_W + TYPE_W;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OOM       = 3'd1,
        ST_FULL      = 3'd2,
        ST_COMMITTED = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    localparam logic [1:0] REG_USABLE = 2'd0;
    localparam logic [1:0] REG_LOADER = 2'd1;
    localparam logic [1:0] REG_KERNEL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LAST_RD,
        S_LAST_CHK,
        S_WR_SRC,
        S_WR_NEW,
        S_READ_RD,
        S_READ_OUT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic [TYPE_W-1:0]  rtype;
    } entry_t;

endpackage

FILE: hw/rtl/ffpra_ram.sv
module ffpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/first_fit_page_region_allocator.sv
// flow from accept to result: load and commit go to done; read reads, registers, done;
// allocate reads and checks entries in turn, then checks the last-added entry and writes
// throughput: one word at a time, no new word until the result is taken; the shared
// compare/add datapath and the single table ram port walk the entries one at a time
// reset: aresetn synchronous active low; clears count, last-added slot and frozen flag and
// restores the config registers to their reset codes; the region table itself is not cleared
module first_fit_page_region_allocator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], entry_index[11:2], entry_base[75:12], entry_length_bytes[139:76],
    // entry_type[155:140], alloc_pages[207:156], for_kernel[208], zero pad
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], alloc_address[66:3], read_base[130:67], read_length_bytes[194:131],
    // read_type[210:195], valid_count[221:211], committed[222], zero pad
    output logic [223:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);
    import ffpra_pkg::*;

    // input fields
    cmd_t                in_cmd;
    logic [IDX_W-1:0]    in_idx;
    logic [ADDR_W-1:0]   in_base;
    logic [ADDR_W-1:0]   in_len;
    logic [TYPE_W-1:0]   in_type;
    logic [PAGES_W-1:0]  in_req;
    logic                in_kern;
    assign in_cmd  = cmd_t'(s_tdata[1:0]);
    assign in_idx  = s_tdata[11:2];
    assign in_base = s_tdata[75:12];
    assign in_len  = s_tdata[139:76];
    assign in_type = s_tdata[155:140];
    assign in_req  = s_tdata[207:156];
    assign in_kern = s_tdata[208];

    // config registers
    logic [TYPE_W-1:0] usable_reg, loader_reg, kernel_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            usable_reg <= '0;
            loader_reg <= 16'd4096;
            kernel_reg <= 16'd6;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_USABLE: usable_reg <= cfg_wdata;
                REG_LOADER: loader_reg <= cfg_wdata;
                REG_KERNEL: kernel_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control and latched command
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   last_reg;
    logic               last_valid_reg;
    logic               frozen_reg;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;     // scan pointer
    logic [IDX_W-1:0]   hit_reg;               // found slot
    entry_t             hit_entry_reg;
    logic [PAGES_W-1:0] req_reg;
    logic [TYPE_W-1:0]  want_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               grow_reg;
    status_t            status_reg;
    logic [ADDR_W-1:0]  addr_reg, rbase_reg, rlen_reg;
    logic [TYPE_W-1:0]  rtype_reg;
    logic               outv_reg;

    // table ram
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, ram_rdata;

    ffpra_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic accept;
    assign s_tready = (state_reg == S_IDLE) && !outv_reg;
    assign accept   = s_tvalid && s_tready;

    // shared datapath: fit compares and the end-address add on ram_rdata
    logic [ADDR_W-1:0]  end_addr;
    logic               fits, exact;
    logic               grow_hit;
    logic [PAGES_W-1:0] pages_load;
    assign fits  = (ram_rdata.pages >= req_reg) && (ram_rdata.rtype == usable_reg);
    assign exact = ram_rdata.pages == req_reg;
    assign end_addr = ram_rdata.base + {ram_rdata.pages, {PAGE_SHIFT{1'b0}}};
    // last-added entry has the wanted type and ends right at the found region
    assign grow_hit = last_valid_reg && (ram_rdata.rtype == want_reg)
                      && (end_addr == hit_entry_reg.base);
    // byte length to pages, drops the low 12 bits (the 52-bit result always fits)
    assign pages_load = in_len[ADDR_W-1:PAGE_SHIFT];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_ALLOC: state_next = (frozen_reg || count_reg == '0)
                                                ? S_DONE : S_SCAN_RD;
                        CMD_READ:  state_next = ({1'b0, in_idx} >= count_reg)
                                                ? S_DONE : S_READ_RD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (fits) begin
                    if (exact) state_next = S_DONE;
                    else if (last_valid_reg) state_next = S_LAST_RD;
                    else state_next = S_LAST_CHK;
                end else if ({1'b0, ptr_reg} + 1'b1 >= count_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_LAST_RD:  state_next = S_LAST_CHK;
            S_LAST_CHK: state_next = (grow_hit || count_reg < CNT_W'(TABLE_DEPTH))
                                     ? S_WR_SRC : S_DONE;
            S_WR_SRC:   state_next = grow_reg ? S_DONE : S_WR_NEW;
            S_WR_NEW:   state_next = S_DONE;
            S_READ_RD:  state_next = S_READ_OUT;
            S_READ_OUT: state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // ram control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = hit_reg;
        ram_wdata = hit_entry_reg;
        ram_raddr = ptr_reg;
        ptr_next  = ptr_reg;
        unique case (state_reg)
            S_IDLE: begin
                ptr_next  = '0;
                ram_raddr = in_idx;
                if (accept && in_cmd == CMD_LOAD) begin
                    ram_we    = 1'b1;
                    ram_waddr = in_idx;
                    ram_wdata = '{base: in_base, pages: pages_load, rtype: in_type};
                end
            end
            S_SCAN_CHK: begin
                ptr_next  = ptr_reg + 1'b1;
                ram_raddr = last_reg;
                if (fits && exact) begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg;
                    ram_wdata = '{base: ram_rdata.base, pages: ram_rdata.pages,
                                  rtype: want_reg};
                end
            end
            S_LAST_RD: ram_raddr = last_reg;
            S_WR_SRC: begin
                ram_we    = 1'b1;
                ram_waddr = hit_reg;
                ram_wdata = '{base: hit_entry_reg.base + {req_reg, {PAGE_SHIFT{1'b0}}},
                              pages: hit_entry_reg.pages - req_reg,
                              rtype: hit_entry_reg.rtype};
            end
            S_WR_NEW: begin
                ram_we    = 1'b1;
                ram_waddr = count_reg[IDX_W-1:0];
                ram_wdata = '{base: hit_entry_reg.base, pages: req_reg, rtype: want_reg};
            end
            S_READ_RD: ram_raddr = idx_reg;
            S_DONE: begin
                // the grown last entry is written in the done cycle
                if (grow_reg) begin
                    ram_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // grow write of the last-added entry shares the port: the grown values are
    // held in the hit registers after the source write and written in the done cycle
    entry_t last_entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            frozen_reg     <= 1'b0;
            outv_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            if (outv_reg && m_tready) outv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        idx_reg    <= in_idx;
                        req_reg    <= in_req;
                        want_reg   <= in_kern ? kernel_reg : loader_reg;
                        status_reg <= ST_OK;
                        addr_reg   <= '0;
                        rbase_reg  <= '0;
                        rlen_reg   <= '0;
                        rtype_reg  <= '0;
                        grow_reg   <= 1'b0;
                        unique case (in_cmd)
                            CMD_LOAD: begin
                                count_reg  <= {1'b0, in_idx} + 1'b1;
                                frozen_reg <= 1'b0;
                            end
                            CMD_ALLOC: begin
                                if (frozen_reg) status_reg <= ST_COMMITTED;
                                else if (count_reg == '0) status_reg <= ST_OOM;
                            end
                            CMD_COMMIT: frozen_reg <= 1'b1;
                            CMD_READ: begin
                                if ({1'b0, in_idx} >= count_reg)
                                    status_reg <= ST_BAD_INDEX;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN_CHK: begin
                    hit_reg       <= ptr_reg;
                    hit_entry_reg <= ram_rdata;
                    if (fits) begin
                        if (exact) addr_reg <= ram_rdata.base;
                    end else if ({1'b0, ptr_reg} + 1'b1 >= count_reg) begin
                        status_reg <= ST_OOM;
                    end
                end
                S_LAST_RD: ;
                S_LAST_CHK: begin
                    last_entry_reg <= ram_rdata;
                    if (grow_hit) begin
                        grow_reg <= 1'b1;
                        addr_reg <= hit_entry_reg.base;
                    end else if (count_reg < CNT_W'(TABLE_DEPTH)) begin
                        addr_reg <= hit_entry_reg.base;
                    end else begin
                        status_reg <= ST_FULL;
                    end
                end
                S_WR_SRC: begin
                    if (grow_reg) begin
                        // reuse the hit entry register to carry the grown last entry
                        hit_reg       <= last_reg;
                        hit_entry_reg <= '{base: last_entry_reg.base,
                                           pages: last_entry_reg.pages + req_reg,
                                           rtype: last_entry_reg.rtype};
                    end
                end
                S_WR_NEW: begin
                    last_reg       <= count_reg[IDX_W-1:0];
                    last_valid_reg <= 1'b1;
                    count_reg      <= count_reg + 1'b1;
                end
                S_READ_OUT: begin
                    rbase_reg <= ram_rdata.base;
                    rlen_reg  <= {ram_rdata.pages, {PAGE_SHIFT{1'b0}}};
                    rtype_reg <= ram_rdata.rtype;
                end
                S_DONE: begin
                    outv_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = outv_reg;
    assign m_tdata  = {1'b0, frozen_reg, count_reg, rtype_reg, rlen_reg, rbase_reg,
                       addr_reg, status_reg};

    // a new word is never taken while a result waits
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        outv_reg |-> !s_tready) else $error("accept while result pending");
    // the table never holds more than its depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH)) else $error("entry count overflow");
    // reaching the done state always raises the result valid
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |=> m_tvalid) else $error("result lost");

endmodule

FILE: test/tb_first_fit_page_region_allocator.sv
module tb_first_fit_page_region_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import ffpra_pkg::*;

    // one result word, fields as the block reports them, status in the low bits
    typedef struct packed {
        logic        frozen;
        logic [10:0] count;
        logic [15:0] rd_type;
        logic [63:0] rd_len;
        logic [63:0] rd_base;
        logic [63:0] alloc_addr;
        logic [2:0]  status;
    } outcome_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // command, entry_index, entry_base, entry_length_bytes, entry_type,
    // alloc_pages, for_kernel, zero pad
    logic [215:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // status, alloc_address, read_base, read_length_bytes, read_type,
    // valid count, committed, zero pad
    logic [223:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_wdata = '0;

    first_fit_page_region_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // words waiting for the driver and results still owed by the block
    logic [215:0] cmd_words[$];
    outcome_t     owed_results[$];

    int src_idle = 0;
    int snk_idle = 0;
    int hold_left = 0;
    bit hold_go = 1'b0;
    bit hold_taken = 1'b0;
    int errors = 0;

    // shadow of the region table and control state
    logic [63:0] map_base [TABLE_DEPTH];
    logic [51:0] map_pages[TABLE_DEPTH];
    logic [15:0] map_type [TABLE_DEPTH];
    int          map_count = 0;
    int          newest_slot = 0;
    bit          newest_valid = 0;
    bit          map_frozen = 0;
    // slots below this have all been written at least once
    int          filled_top = 0;

    logic [15:0] usable_ty = 16'd0;
    logic [15:0] loader_ty = 16'd4096;
    logic [15:0] kernel_ty = 16'd6;

    // first-fit allocate against the shadow table
    function automatic logic [2:0] map_allocate(input logic [51:0] req,
                                                input logic [15:0] want,
                                                output logic [63:0] addr);
        logic [63:0] found;
        logic [63:0] tail;
        addr = '0;
        for (int i = 0; i < map_count; i++) begin
            if (map_pages[i] < req || map_type[i] != usable_ty) continue;
            found = map_base[i];
            if (map_pages[i] == req) begin
                // exact fit, whole region changes type
                map_type[i] = want;
                addr = found;
                return ST_OK;
            end
            if (newest_valid) begin
                tail = map_base[newest_slot] + {map_pages[newest_slot], 12'b0};
                if (map_type[newest_slot] == want && tail == found) begin
                    // newest region sits right below: grow it
                    map_pages[newest_slot] = map_pages[newest_slot] + req;
                    map_pages[i] = map_pages[i] - req;
                    map_base[i] = found + {req, 12'b0};
                    addr = found;
                    return ST_OK;
                end
            end
            if (map_count >= TABLE_DEPTH) return ST_FULL;
            map_base[map_count] = found;
            map_type[map_count] = want;
            map_pages[map_count] = req;
            newest_slot = map_count;
            newest_valid = 1;
            if (map_count == filled_top) filled_top++;
            map_count++;
            map_base[i] = found + {req, 12'b0};
            map_pages[i] = map_pages[i] - req;
            addr = found;
            return ST_OK;
        end
        return ST_OOM;
    endfunction

    // predict one command, queue the word and its expected result
    task automatic send_cmd(input cmd_t cmd, input logic [9:0] idx,
                            input logic [63:0] base, input logic [63:0] len,
                            input logic [15:0] ty, input logic [51:0] pages,
                            input logic fk);
        outcome_t r;
        logic [63:0] pg;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_LOAD: begin
                pg = len >> PAGE_SHIFT;
                map_base[idx] = base;
                map_pages[idx] = pg[51:0];
                map_type[idx] = ty;
                map_count = int'(idx) + 1;
                map_frozen = 0;
                if (int'(idx) == filled_top) filled_top++;
            end
            CMD_ALLOC: begin
                if (map_frozen) begin
                    r.status = ST_COMMITTED;
                end else begin
                    r.status = map_allocate(pages, fk ? kernel_ty : loader_ty,
                                            r.alloc_addr);
                    if (r.status != ST_OK) r.alloc_addr = '0;
                end
            end
            CMD_COMMIT: begin
                map_frozen = 1;
            end
            default: begin
                if (int'(idx) >= map_count) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    r.rd_base = map_base[idx];
                    r.rd_len = {map_pages[idx], 12'b0};
                    r.rd_type = map_type[idx];
                end
            end
        endcase
        r.count = map_count[10:0];
        r.frozen = map_frozen;
        cmd_words.push_back({7'b0, fk, pages, ty, len, base, idx, cmd});
        owed_results.push_back(r);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_USABLE: usable_ty = val;
            REG_LOADER: loader_ty = val;
            default:    kernel_ty = val;
        endcase
    endtask

    // wait until every word went in and every result came back
    task automatic drain();
        do @(posedge aclk);
        while (cmd_words.size() != 0 || owed_results.size() != 0 || s_tvalid);
        repeat (10) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one random command; mostly small tables so scans stay short
    task automatic send_random();
        int sel;
        int top;
        logic [15:0] ty;
        logic [51:0] req;
        logic [63:0] len;
        sel = $urandom_range(0, 99);
        if (sel < 30 || map_count > 40) begin
            top = (filled_top < 24) ? filled_top : 24;
            case ($urandom_range(0, 9))
                0, 1:    ty = 16'(rand64());
                2:       ty = loader_ty;
                3:       ty = kernel_ty;
                default: ty = usable_ty;
            endcase
            if ($urandom_range(0, 9) == 0) len = rand64();
            else len = 64'({$urandom_range(0, 40), 12'b0}) + 64'($urandom_range(0, 4095));
            send_cmd(CMD_LOAD, 10'($urandom_range(0, top)),
                     ($urandom_range(0, 3) == 0) ? rand64() : rand64() & ~64'hfff,
                     len, ty, 52'(rand64()), 1'($urandom_range(0, 1)));
        end else if (sel < 72) begin
            if ($urandom_range(0, 5) == 0) req = 52'(rand64());
            else req = 52'($urandom_range(0, 12));
            send_cmd(CMD_ALLOC, 10'(rand64()), rand64(), rand64(), 16'(rand64()), req,
                     1'($urandom_range(0, 1)));
        end else if (sel < 77) begin
            send_cmd(CMD_COMMIT, 10'(rand64()), rand64(), rand64(), 16'(rand64()),
                     52'(rand64()), 1'($urandom_range(0, 1)));
        end else begin
            send_cmd(CMD_READ, ($urandom_range(0, 4) == 0) ? 10'(rand64()) :
                     10'($urandom_range(0, 30)), rand64(), rand64(), 16'(rand64()),
                     52'(rand64()), 1'($urandom_range(0, 1)));
        end
    endtask

    // driver: offers the next queued word, idling at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (cmd_words.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
                s_tvalid <= 1'b1;
                s_tdata <= cmd_words.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off counted here
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= 500;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    // monitor: every result word against the oldest expectation
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[222:0];
            if (owed_results.size() == 0) begin
                errors++;
                $display("%t unexpected result word %h", $realtime, got);
            end else begin
                want = owed_results.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors < 40) begin
                        $display("%t mismatch: expected st=%0d addr=%h rb=%h rl=%h rt=%h cnt=%0d fr=%0d",
                                 $realtime, want.status, want.alloc_addr, want.rd_base,
                                 want.rd_len, want.rd_type, want.count, want.frozen);
                        $display("%t            actual st=%0d addr=%h rb=%h rl=%h rt=%h cnt=%0d fr=%0d",
                                 $realtime, got.status, got.alloc_addr, got.rd_base,
                                 got.rd_len, got.rd_type, got.count, got.frozen);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phase one: sender idles a little, receiver a lot, reset codes
        src_idle = 14;
        snk_idle = 80;
        write_reg(REG_USABLE, 16'd0);
        write_reg(REG_LOADER, 16'd4096);
        write_reg(REG_KERNEL, 16'd6);

        // directed: read of an empty table, loads, append, grow, exact fit
        send_cmd(CMD_READ, 10'd0, '0, '0, '0, '0, 1'b0);
        send_cmd(CMD_LOAD, 10'd0, 64'h10_0000, 64'h1_0fff, usable_ty, '0, 1'b0);
        send_cmd(CMD_LOAD, 10'd1, '1, '1, usable_ty, '0, 1'b1);
        send_cmd(CMD_LOAD, 10'd2, 64'h5000, 64'hfff, usable_ty, '0, 1'b0);
        send_cmd(CMD_READ, 10'd1, '0, '0, '0, '0, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd4, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd4, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd8, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd0, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, '1, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd3, 1'b1);
        send_cmd(CMD_READ, 10'd3, '0, '0, '0, '0, 1'b0);
        send_cmd(CMD_READ, 10'd1023, '0, '0, '0, '0, 1'b0);
        send_cmd(CMD_COMMIT, '0, '0, '0, '0, '0, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd1, 1'b0);
        send_cmd(CMD_READ, 10'd0, '0, '0, '0, '0, 1'b0);
        send_cmd(CMD_LOAD, 10'd3, '0, '0, 16'hffff, '0, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd1, 1'b0);
        send_cmd(CMD_READ, 10'd3, '0, '0, '0, '0, 1'b0);
        repeat (300) send_random();
        drain();

        // phase two: roles swapped, codes at their extremes
        src_idle = 80;
        snk_idle = 14;
        write_reg(REG_USABLE, 16'hffff);
        write_reg(REG_LOADER, 16'h0000);
        write_reg(REG_KERNEL, 16'hffff);
        repeat (150) send_random();
        // receiver holds off while the sender keeps offering
        @(negedge aclk);
        hold_go = 1'b1;
        repeat (150) send_random();
        drain();

        // phase three: no idling, fill the whole table
        src_idle = 0;
        snk_idle = 0;
        write_reg(REG_USABLE, 16'h1234);
        write_reg(REG_LOADER, 16'hffff);
        write_reg(REG_KERNEL, 16'h0000);
        send_cmd(CMD_LOAD, 10'd0, 64'h4000_0000, 64'd100 << 12, usable_ty, '0, 1'b0);
        for (int i = 1; i < TABLE_DEPTH; i++)
            send_cmd(CMD_LOAD, 10'(i), rand64(), rand64(), 16'h4321, '0, 1'b0);
        send_cmd(CMD_READ, 10'd1023, '0, '0, '0, '0, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd5, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd100, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0, '0, '0, 52'd1, 1'b0);
        send_cmd(CMD_LOAD, 10'd3, 64'h9000, 64'd20 << 12, usable_ty, '0, 1'b0);
        repeat (200) send_random();
        drain();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
